>>> design/vco_pkg.sv
package vco_pkg;

  localparam int NUM_FACES   = 6;
  localparam int NUM_CORNERS = 4;
  localparam int NUM_CELLS   = 27;
  localparam int SHADE_W     = 4;
  localparam int CORNER_MAX  = 32;

  typedef logic [2:0]  face_t;
  typedef logic [4:0]  cell_idx_t;
  typedef logic [3:0]  shade_t;
  typedef logic [1:0]  level_t;
  typedef logic [5:0]  corner_val_t;

  localparam face_t LAST_FACE = face_t'(NUM_FACES - 1);

  // per-face control that travels down the pipeline
  typedef struct packed {
    logic  valid;
    face_t face;
    logic  last;
  } pipe_ctl_t;

  // the cells one corner needs: corner bit, two side bits, four shades
  typedef struct packed {
    logic [2:0]   occ;
    shade_t [3:0] shade;
  } corner_cells_t;

  // level scaled by eight plus the first shade pair, then the second pair
  typedef struct packed {
    logic [5:0] head;
    logic [4:0] tail;
  } corner_part_t;

  // corner cell, then the two side cells
  localparam cell_idx_t OCC_CELLS [NUM_FACES][NUM_CORNERS][3] = '{
    '{'{5'd0,  5'd1,  5'd9},  '{5'd2,  5'd1,  5'd11},
      '{5'd20, 5'd11, 5'd19}, '{5'd18, 5'd9,  5'd19}},
    '{'{5'd18, 5'd19, 5'd21}, '{5'd20, 5'd19, 5'd23},
      '{5'd26, 5'd23, 5'd25}, '{5'd24, 5'd21, 5'd25}},
    '{'{5'd20, 5'd11, 5'd23}, '{5'd2,  5'd5,  5'd11},
      '{5'd8,  5'd17, 5'd5},  '{5'd26, 5'd17, 5'd23}},
    '{'{5'd2,  5'd1,  5'd5},  '{5'd0,  5'd1,  5'd3},
      '{5'd6,  5'd3,  5'd7},  '{5'd8,  5'd5,  5'd7}},
    '{'{5'd0,  5'd3,  5'd9},  '{5'd18, 5'd9,  5'd21},
      '{5'd24, 5'd15, 5'd21}, '{5'd6,  5'd3,  5'd15}},
    '{'{5'd6,  5'd7,  5'd15}, '{5'd24, 5'd15, 5'd25},
      '{5'd26, 5'd17, 5'd25}, '{5'd8,  5'd7,  5'd17}}
  };

  localparam cell_idx_t SHADE_CELLS [NUM_FACES][NUM_CORNERS][4] = '{
    '{'{5'd0,  5'd1,  5'd9,  5'd10}, '{5'd1,  5'd2,  5'd10, 5'd11},
      '{5'd10, 5'd11, 5'd19, 5'd20}, '{5'd9,  5'd10, 5'd18, 5'd19}},
    '{'{5'd18, 5'd19, 5'd21, 5'd22}, '{5'd19, 5'd20, 5'd22, 5'd23},
      '{5'd22, 5'd23, 5'd25, 5'd26}, '{5'd21, 5'd22, 5'd24, 5'd25}},
    '{'{5'd11, 5'd14, 5'd20, 5'd23}, '{5'd2,  5'd5,  5'd11, 5'd14},
      '{5'd5,  5'd8,  5'd14, 5'd17}, '{5'd14, 5'd17, 5'd23, 5'd26}},
    '{'{5'd1,  5'd2,  5'd4,  5'd5},  '{5'd0,  5'd1,  5'd3,  5'd4},
      '{5'd3,  5'd4,  5'd6,  5'd7},  '{5'd4,  5'd5,  5'd7,  5'd8}},
    '{'{5'd0,  5'd3,  5'd9,  5'd12}, '{5'd9,  5'd18, 5'd12, 5'd21},
      '{5'd12, 5'd15, 5'd21, 5'd24}, '{5'd3,  5'd6,  5'd12, 5'd15}},
    '{'{5'd6,  5'd7,  5'd15, 5'd16}, '{5'd15, 5'd16, 5'd24, 5'd25},
      '{5'd16, 5'd17, 5'd25, 5'd26}, '{5'd7,  5'd8,  5'd16, 5'd17}}
  };

endpackage

>>> design/vco_issue.sv
module vco_issue
  import vco_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [NUM_CELLS-1:0]            neighbor_bits,
  input  logic [NUM_CELLS*SHADE_W-1:0]    shades_in,
  output logic                            busy,
  output pipe_ctl_t                       ctl,
  output logic [NUM_CELLS-1:0]            bits,
  output logic [NUM_CELLS*SHADE_W-1:0]    shades
);

  logic  active;
  face_t face_cnt;
  logic  accept;

  assign busy   = active && (face_cnt != LAST_FACE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      face_cnt <= '0;
    end else if (accept) begin
      active   <= 1'b1;
      face_cnt <= '0;
    end else if (active) begin
      if (face_cnt == LAST_FACE) begin
        active <= 1'b0;
      end else begin
        face_cnt <= face_cnt + face_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bits   <= neighbor_bits;
      shades <= shades_in;
    end
  end

  assign ctl.valid = active;
  assign ctl.face  = face_cnt;
  assign ctl.last  = (face_cnt == LAST_FACE);

endmodule

>>> design/vco_gather.sv
module vco_gather
  import vco_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  pipe_ctl_t                       ctl_in,
  input  logic [NUM_CELLS-1:0]            bits,
  input  logic [NUM_CELLS*SHADE_W-1:0]    shades,
  output pipe_ctl_t                       ctl_out,
  output corner_cells_t [NUM_CORNERS-1:0] cells
);

  corner_cells_t [NUM_CORNERS-1:0] cells_next;

  // per-face table lookup of the cells each corner needs
  always_comb begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      for (int k = 0; k < 3; k++) begin
        cells_next[c].occ[k] = bits[OCC_CELLS[ctl_in.face][c][k]];
      end
      for (int k = 0; k < 4; k++) begin
        cells_next[c].shade[k] = shades[{SHADE_CELLS[ctl_in.face][c][k], 2'b00} +: SHADE_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    ctl_out.face <= ctl_in.face;
    ctl_out.last <= ctl_in.last;
    cells        <= cells_next;
  end

endmodule

>>> design/vco_accum.sv
module vco_accum
  import vco_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  pipe_ctl_t                       ctl_in,
  input  corner_cells_t [NUM_CORNERS-1:0] cells,
  output pipe_ctl_t                       ctl_out,
  output corner_val_t [NUM_CORNERS-1:0]   values
);

  pipe_ctl_t                      ctl_mid;
  corner_part_t [NUM_CORNERS-1:0] parts;
  corner_part_t [NUM_CORNERS-1:0] parts_next;
  corner_val_t  [NUM_CORNERS-1:0] values_next;

  // occlusion level and shade pair sums
  always_comb begin
    level_t lvl;
    for (int c = 0; c < NUM_CORNERS; c++) begin
      if (cells[c].occ[1] && cells[c].occ[2]) begin
        lvl = 2'd3;
      end else begin
        lvl = level_t'({1'b0, cells[c].occ[0]} + {1'b0, cells[c].occ[1]}
                       + {1'b0, cells[c].occ[2]});
      end
      parts_next[c].head = {1'b0, lvl, 3'b000}
                           + 6'({1'b0, cells[c].shade[0]} + {1'b0, cells[c].shade[1]});
      parts_next[c].tail = {1'b0, cells[c].shade[2]} + {1'b0, cells[c].shade[3]};
    end
  end

  // final add and saturation
  always_comb begin
    logic [6:0] total;
    for (int c = 0; c < NUM_CORNERS; c++) begin
      total = {1'b0, parts[c].head} + {2'b00, parts[c].tail};
      if (total > 7'(CORNER_MAX)) begin
        values_next[c] = corner_val_t'(CORNER_MAX);
      end else begin
        values_next[c] = total[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_mid.valid <= 1'b0;
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_mid.valid <= ctl_in.valid;
      ctl_out.valid <= ctl_mid.valid;
    end
  end

  always_ff @(posedge clk) begin
    ctl_mid.face <= ctl_in.face;
    ctl_mid.last <= ctl_in.last;
    parts        <= parts_next;
    ctl_out.face <= ctl_mid.face;
    ctl_out.last <= ctl_mid.last;
    values       <= values_next;
  end

endmodule

>>> design/voxel_corner_occlusion_unit.sv
// Corner ambient occlusion for one voxel. Raise start with the 27 opacity
// bits and 27 shade nibbles; the transaction is taken when busy is low. The
// unit then issues one face per cycle into a four-stage pipeline (issue,
// cell lookup, level and pair sums, final sum and saturation), so six
// results follow in consecutive cycles, face 0 first, each marked by strobe
// for one cycle. busy drops during the sixth face's issue cycle, so a new
// voxel accepted then keeps the result port fully used. Results cannot be
// held off: the receiver must take strobe cycles as they come.
module voxel_corner_occlusion_unit
  import vco_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [26:0] neighbor_bits,
  input  logic [55:0] shades_low,
  input  logic [51:0] shades_high,
  output logic        strobe,
  output logic [2:0]  face,
  output logic [5:0]  corner_zero,
  output logic [5:0]  corner_one,
  output logic [5:0]  corner_two,
  output logic [5:0]  corner_three,
  output logic        last_face
);

  pipe_ctl_t                       ctl_issue;
  pipe_ctl_t                       ctl_gather;
  pipe_ctl_t                       ctl_done;
  logic [NUM_CELLS-1:0]            bits;
  logic [NUM_CELLS*SHADE_W-1:0]    shades;
  corner_cells_t [NUM_CORNERS-1:0] cells;
  corner_val_t [NUM_CORNERS-1:0]   values;

  vco_issue u_issue (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .neighbor_bits (neighbor_bits),
    .shades_in     ({shades_high, shades_low}),
    .busy          (busy),
    .ctl           (ctl_issue),
    .bits          (bits),
    .shades        (shades)
  );

  vco_gather u_gather (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_issue),
    .bits    (bits),
    .shades  (shades),
    .ctl_out (ctl_gather),
    .cells   (cells)
  );

  vco_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_gather),
    .cells   (cells),
    .ctl_out (ctl_done),
    .values  (values)
  );

  assign strobe       = ctl_done.valid;
  assign face         = ctl_done.face;
  assign last_face    = ctl_done.last;
  assign corner_zero  = values[0];
  assign corner_one   = values[1];
  assign corner_two   = values[2];
  assign corner_three = values[3];

endmodule

>>> tb/voxel_occlusion_monitor.sv
module voxel_occlusion_monitor
  import vco_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [26:0] neighbor_bits,
  input  logic [55:0] shades_low,
  input  logic [51:0] shades_high,
  input  logic        strobe,
  input  logic [2:0]  face,
  input  logic [5:0]  corner_zero,
  input  logic [5:0]  corner_one,
  input  logic [5:0]  corner_two,
  input  logic [5:0]  corner_three,
  input  logic        last_face,
  output int          errors,
  output int          pending,
  output int          checked
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORNER_CEILING = 32;

  // per face and corner: corner cell, then the two side cells
  localparam int OCCLUDER_CELL [72] = '{
    0, 1, 9,     2, 1, 11,    20, 11, 19,  18, 9, 19,
    18, 19, 21,  20, 19, 23,  26, 23, 25,  24, 21, 25,
    20, 11, 23,  2, 5, 11,    8, 17, 5,    26, 17, 23,
    2, 1, 5,     0, 1, 3,     6, 3, 7,     8, 5, 7,
    0, 3, 9,     18, 9, 21,   24, 15, 21,  6, 3, 15,
    6, 7, 15,    24, 15, 25,  26, 17, 25,  8, 7, 17
  };

  // per face and corner: the four cells whose shades add up
  localparam int SHADE_CELL [96] = '{
    0, 1, 9, 10,     1, 2, 10, 11,    10, 11, 19, 20,  9, 10, 18, 19,
    18, 19, 21, 22,  19, 20, 22, 23,  22, 23, 25, 26,  21, 22, 24, 25,
    11, 14, 20, 23,  2, 5, 11, 14,    5, 8, 14, 17,    14, 17, 23, 26,
    1, 2, 4, 5,      0, 1, 3, 4,      3, 4, 6, 7,      4, 5, 7, 8,
    0, 3, 9, 12,     9, 18, 12, 21,   12, 15, 21, 24,  3, 6, 12, 15,
    6, 7, 15, 16,    15, 16, 24, 25,  16, 17, 25, 26,  7, 8, 16, 17
  };

  typedef struct packed {
    face_t                   face;
    corner_val_t [3:0]       corner;
    logic                    last;
  } face_result_t;

  face_result_t expected_faces[$];

  function automatic corner_val_t corner_occlusion(input logic [26:0] bits,
                                                   input logic [107:0] shades,
                                                   input int f, input int c);
    int   occ_base;
    int   shade_base;
    int   level;
    int   total;
    logic corner_bit;
    logic side_a;
    logic side_b;
    occ_base   = (f * NUM_CORNERS + c) * 3;
    shade_base = (f * NUM_CORNERS + c) * 4;
    corner_bit = bits[OCCLUDER_CELL[occ_base]];
    side_a     = bits[OCCLUDER_CELL[occ_base + 1]];
    side_b     = bits[OCCLUDER_CELL[occ_base + 2]];
    if (side_a && side_b) level = 3;
    else level = int'(corner_bit) + int'(side_a) + int'(side_b);
    total = 8 * level;
    for (int k = 0; k < 4; k++) begin
      total += int'(shades[4 * SHADE_CELL[shade_base + k] +: 4]);
    end
    if (total > CORNER_CEILING) total = CORNER_CEILING;
    return corner_val_t'(total);
  endfunction

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    face_result_t exp_face;
    logic [107:0] shades;
    if (rst) begin
      expected_faces.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (start && !busy) begin
        shades = {shades_high, shades_low};
        for (int f = 0; f < NUM_FACES; f++) begin
          exp_face.face = face_t'(f);
          exp_face.last = (f == NUM_FACES - 1);
          for (int c = 0; c < NUM_CORNERS; c++) begin
            exp_face.corner[c] = corner_occlusion(neighbor_bits, shades, f, c);
          end
          expected_faces.push_back(exp_face);
        end
      end
      if (strobe) begin
        if (expected_faces.size() == 0) begin
          errors++;
          $display("%0t: unexpected face result, face %0d", $time, face);
        end else begin
          exp_face = expected_faces.pop_front();
          checked++;
          report_field("face", exp_face.face, face);
          report_field("corner_zero", exp_face.corner[0], corner_zero);
          report_field("corner_one", exp_face.corner[1], corner_one);
          report_field("corner_two", exp_face.corner[2], corner_two);
          report_field("corner_three", exp_face.corner[3], corner_three);
          report_field("last_face", exp_face.last, last_face);
        end
      end
    end
    pending = expected_faces.size();
  end

endmodule

>>> tb/voxel_corner_occlusion_unit_test.sv
module voxel_corner_occlusion_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_VOXELS = 380;
  localparam int STALL_LIMIT   = 200;

  // cube corners and cube edges of the 3x3x3 neighborhood
  localparam logic [26:0] CORNER_CELLS = 27'h5140145;
  localparam logic [26:0] EDGE_CELLS   = 27'h2AA8AAA;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [26:0] neighbor_bits = '0;
  logic [55:0] shades_low = '0;
  logic [51:0] shades_high = '0;
  logic        strobe;
  logic [2:0]  face;
  logic [5:0]  corner_zero;
  logic [5:0]  corner_one;
  logic [5:0]  corner_two;
  logic [5:0]  corner_three;
  logic        last_face;

  int errors;
  int pending;
  int checked;
  int voxels_sent = 0;
  int stall_cycles = 0;
  bit burst = 1'b0;

  always #4 clk = ~clk;

  voxel_corner_occlusion_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .neighbor_bits(neighbor_bits),
    .shades_low   (shades_low),
    .shades_high  (shades_high),
    .strobe       (strobe),
    .face         (face),
    .corner_zero  (corner_zero),
    .corner_one   (corner_one),
    .corner_two   (corner_two),
    .corner_three (corner_three),
    .last_face    (last_face)
  );

  voxel_occlusion_monitor i_monitor (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .neighbor_bits(neighbor_bits),
    .shades_low   (shades_low),
    .shades_high  (shades_high),
    .strobe       (strobe),
    .face         (face),
    .corner_zero  (corner_zero),
    .corner_one   (corner_one),
    .corner_two   (corner_two),
    .corner_three (corner_three),
    .last_face    (last_face),
    .errors       (errors),
    .pending      (pending),
    .checked      (checked)
  );

  // one transaction, driven at the falling edge, held until taken
  task automatic send_voxel(input logic [26:0] bits, input logic [107:0] shades);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         = 1'b1;
    neighbor_bits = bits;
    shades_low    = shades[55:0];
    shades_high   = shades[107:56];
    do @(posedge clk); while (busy);
    @(negedge clk);
    voxels_sent++;
  endtask

  function automatic logic [107:0] random_shades(input int mode);
    logic [107:0] v;
    for (int n = 0; n < 27; n++) begin
      case (mode)
        0: v[4*n +: 4] = 4'($urandom_range(0, 8));
        1: v[4*n +: 4] = 4'($urandom_range(0, 2));
        2: v[4*n +: 4] = 4'($urandom_range(0, 15));
        default: v[4*n +: 4] = $urandom_range(0, 1) ? 4'd8 : 4'd0;
      endcase
    end
    return v;
  endfunction

  function automatic logic [26:0] random_bits(input int mode);
    case (mode)
      0: return 27'($urandom);
      1: return 27'($urandom | $urandom);
      default: return 27'($urandom & $urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d faces still due",
                 $time, stall_cycles, pending);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int directed;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_voxel('0, '0);
    send_voxel('1, '0);
    send_voxel('0, {27{4'd8}});
    send_voxel('0, {27{4'd1}});
    // shade nibbles above eight
    send_voxel('1, '1);
    send_voxel('0, {27{4'd15}});
    send_voxel(CORNER_CELLS, '0);
    send_voxel(EDGE_CELLS, '0);
    send_voxel(EDGE_CELLS, {27{4'd2}});
    send_voxel(CORNER_CELLS | EDGE_CELLS, {27{4'd1}});
    send_voxel(27'h5555555, {{13{8'h08}}, 4'h0});
    send_voxel(27'h2AAAAAA, {4'h0, {13{8'h80}}});
    // edge cells among cells 0 to 8, then corner and edge cells among cells 18 to 26
    send_voxel(EDGE_CELLS & 27'h00001FF, {27{4'd3}});
    send_voxel((CORNER_CELLS | EDGE_CELLS) & 27'h7FC0000, {27{4'd1}});
    burst = 1'b1;
    send_voxel(27'h0000001, {27{4'd4}});
    send_voxel(27'h4000000, {27{4'd7}});
    send_voxel(27'h0002000, {27{4'd8}});
    burst = 1'b0;
    directed = voxels_sent;

    for (int i = 0; i < RANDOM_VOXELS; i++) begin
      if (i % 40 == 0) burst = ($urandom_range(0, 2) == 0);
      send_voxel(random_bits($urandom_range(0, 2)), random_shades($urandom_range(0, 3)));
    end
    start = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (12) @(posedge clk);

    $display("%0d voxels sent (%0d directed), %0d face results checked, %0d mismatches",
             voxels_sent, directed, checked, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> voxel_corner_occlusion_unit.f
design/vco_pkg.sv
design/vco_issue.sv
design/vco_gather.sv
design/vco_accum.sv
design/voxel_corner_occlusion_unit.sv
tb/voxel_occlusion_monitor.sv
tb/voxel_corner_occlusion_unit_test.sv
